[rtl/lct_pkg.sv]
// ----------------------------------------------------------------------------
// lct_pkg - shared types and constants of the LFU cache table
// Request and response words, register map and controller commands.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic       REG_CAPACITY = 1'b0;  // register index from paddr[2]
  localparam logic [4:0] CAP_RESET    = 5'd16;

  typedef struct packed {
    logic        mode;
    logic [31:0] key;
    logic [31:0] value;
  } lct_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lct_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch request, clear scan state
    logic scan;    // examine one slot
    logic update;  // apply the operation, write the response
  } lct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;    // slot being scanned is the final one
  } lct_sts_t;

endpackage

[rtl/lct_ctrl.sv]
// ----------------------------------------------------------------------------
// lct_ctrl - sequencing of the LFU cache table
// Idle, a slot-by-slot scan, then the update state.
// ----------------------------------------------------------------------------
module lct_ctrl import lct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  lct_sts_t sts_i,
  output lct_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/lct_datapath.sv]
// ----------------------------------------------------------------------------
// lct_datapath - slot storage, scan registers and update logic
// Scans one slot a cycle for hit, free slot and victim, then updates.
// ----------------------------------------------------------------------------
module lct_datapath import lct_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lct_cmd_t cmd_i,
  output lct_sts_t sts_o,
  input  lct_req_t req_i,
  input  logic [4:0] cap_i,
  output logic     done_o,
  output lct_rsp_t rsp_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [31:0] ENTRIES32 = 32'(ENTRIES);

  // slot storage
  logic                  valid_q [ENTRIES];
  logic [31:0]           key_q   [ENTRIES];
  logic [31:0]           val_q   [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_q   [ENTRIES];
  logic [IW-1:0]         rank_q  [ENTRIES];

  // latched request
  lct_req_t   req_q;
  logic [4:0] cap_q;

  // scan state
  logic [IW-1:0]         idx_q;
  logic [UW-1:0]         used_q;
  logic                  hit_q, free_q, vic_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q, vic_idx_q;
  logic [31:0]           hit_val_q, vic_key_q;
  logic [COUNT_BITS-1:0] hit_cnt_q, vic_cnt_q;
  logic [IW-1:0]         hit_rank_q, vic_rank_q;

  logic     done_q;
  lct_rsp_t rsp_q, rsp_d;

  // slot under scan
  logic                  s_valid;
  logic [31:0]           s_key;
  logic [COUNT_BITS-1:0] s_cnt;
  logic [IW-1:0]         s_rank;
  logic                  s_better;

  assign s_valid  = valid_q[idx_q];
  assign s_key    = key_q[idx_q];
  assign s_cnt    = cnt_q[idx_q];
  assign s_rank   = rank_q[idx_q];
  assign s_better = !vic_q || (s_cnt < vic_cnt_q) ||
                    ((s_cnt == vic_cnt_q) && (s_rank > vic_rank_q));

  assign sts_o.last = (idx_q == IW'(ENTRIES - 1));

  // effective capacity, clamped to 1..ENTRIES
  logic [31:0] cap32, cap_eff;
  logic        do_evict, do_insert;
  logic [IW-1:0] ins_idx;

  assign cap32   = {27'd0, cap_q};
  assign cap_eff = (cap32 == 32'd0) ? 32'd1 : ((cap32 > ENTRIES32) ? ENTRIES32 : cap32);
  assign do_evict  = !hit_q && (req_q.mode == MODE_PUT) && vic_q &&
                     ({{(32-UW){1'b0}}, used_q} >= cap_eff);
  assign do_insert = !hit_q && (req_q.mode == MODE_PUT) && (do_evict || free_q);
  assign ins_idx   = do_evict ? vic_idx_q : free_idx_q;

  // response word of the operation under update
  always_comb begin
    rsp_d = '0;
    if (hit_q) begin
      rsp_d.found = 1'b1;
      if (req_q.mode == MODE_GET) rsp_d.read_value = hit_val_q;
    end else if (do_evict) begin
      rsp_d.evicted     = 1'b1;
      rsp_d.evicted_key = vic_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      cap_q <= cap_i;
    end
    if (cmd_i.scan && s_valid) begin
      if (!hit_q && s_key == req_q.key) begin
        hit_idx_q  <= idx_q;
        hit_val_q  <= val_q[idx_q];
        hit_cnt_q  <= s_cnt;
        hit_rank_q <= s_rank;
      end
      if (s_better) begin
        vic_idx_q  <= idx_q;
        vic_key_q  <= s_key;
        vic_cnt_q  <= s_cnt;
        vic_rank_q <= s_rank;
      end
    end
    if (cmd_i.scan && !s_valid && !free_q) free_idx_q <= idx_q;

    if (cmd_i.update) begin
      rsp_q <= rsp_d;
      if (hit_q) begin
        if (req_q.mode == MODE_PUT) val_q[hit_idx_q] <= req_q.value;
        if (hit_cnt_q != CNT_MAX) cnt_q[hit_idx_q] <= hit_cnt_q + 1'b1;
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j] && IW'(j) != hit_idx_q && rank_q[j] < hit_rank_q)
            rank_q[j] <= rank_q[j] + 1'b1;
        end
        rank_q[hit_idx_q] <= '0;
      end else if (do_insert) begin
        // valid slots age by one; on an eviction only survivors newer than the victim do, older ones keep rank
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j] && !(do_evict && rank_q[j] >= vic_rank_q))
            rank_q[j] <= rank_q[j] + 1'b1;
        end
        key_q[ins_idx]  <= req_q.key;
        val_q[ins_idx]  <= req_q.value;
        cnt_q[ins_idx]  <= COUNT_BITS'(1);
        rank_q[ins_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ENTRIES; j++) valid_q[j] <= 1'b0;
      idx_q  <= '0;
      used_q <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      vic_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.load) begin
        idx_q  <= '0;
        used_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (!sts_o.last) idx_q <= idx_q + 1'b1;
        if (s_valid) begin
          used_q <= used_q + 1'b1;
          if (s_key == req_q.key) hit_q <= 1'b1;
          vic_q <= 1'b1;
        end else begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.update && do_insert) valid_q[ins_idx] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(rsp_q.found && rsp_q.evicted))
    else $error("hit reported with eviction");

  // response strobe follows the update cycle
  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> done_q)
    else $error("missing response strobe");

  // eviction only when no free slot or capacity reached
  a_evict_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && do_evict) |-> ({{(32-UW){1'b0}}, used_q} >= cap_eff))
    else $error("eviction below capacity");

endmodule

[rtl/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table - fully associative LFU key-value store, LRU tie-break
// Top level: APB register, controller and datapath.
// ----------------------------------------------------------------------------
// Use:
//   A word (mode, key, value) is taken on req_i when start is high and busy
//   is low. mode 0 is a get, mode 1 a put.
//   One response word appears on rsp_o for exactly one cycle with done_o
//   high; the receiver cannot stall it and must take it then.
// Operation:
//   after acceptance the controller scans one slot a cycle for the key, a
//   free slot and the victim (lowest count, oldest among equals), then
//   applies the update; the done strobe is registered from the update state.
//   busy falls with the strobe, so a new word can follow at once; no new word
//   is taken while one is under way.
// Register (APB, byte address 0): capacity_in_use, 5 bits, reset 16.
//   Values of 0 behave as 1, values above ENTRIES as ENTRIES.
//   Write it only while the block is idle.
// Reset: all slots invalid, capacity 16, no clearing pass needed.
// ----------------------------------------------------------------------------
module lfu_cache_table import lct_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  lct_req_t    req_i,
  // result channel
  output logic        done_o,
  output lct_rsp_t    rsp_o,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lct_cmd_t   cmd;
  lct_sts_t   sts;
  logic [4:0] cap_q;
  logic       cfg_wr;

  // register write on the access phase; pready is tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     cap_q <= CAP_RESET;
    else if (cfg_wr) cap_q <= pwdata[4:0];
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, cap_q} : 32'd0;

  lct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lct_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .cap_i  (cap_q),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
